/* src/x256pp_pkg.sv */
// ----------------------------------------------------------------------------
// x256pp_pkg
// shared types and constants for the xoshiro256++ generator
// ----------------------------------------------------------------------------
package x256pp_pkg;

    localparam int unsigned WORD_W   = 64;
    localparam int unsigned BOUND_W  = 32;
    localparam int unsigned DIV_W    = 31;
    localparam int unsigned ROT_OUT  = 23;
    localparam int unsigned SHIFT_T  = 17;
    localparam int unsigned ROT_W3   = 45;
    localparam int unsigned NUM_SEED = 4;

    typedef enum logic [1:0] {
        OP_RAW   = 2'd0,
        OP_RANGE = 2'd1,
        OP_LOAD  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MIX,
        ST_REM
    } fsm_state_t;

    typedef logic [NUM_SEED-1:0][WORD_W-1:0] seed_t;

    typedef struct packed {
        logic advance;
        logic load;
        logic clear;
    } state_ctrl_t;

endpackage

/* src/xoshiro256pp_random_generator.sv */
// ----------------------------------------------------------------------------
// xoshiro256pp_random_generator
// xoshiro256++ generator with raw, ranged, seed load and clear requests
// ----------------------------------------------------------------------------
// A raw request (operation 0) goes through the mix state and the output
// register; a ranged request (operation 1) with a positive bound goes through
// the mix state, the remainder unit (one dividend bit per cycle over the
// 64-bit output) and the output register. A bound of zero or below returns 0
// without advancing. Seed load and clear give no word. Input is ready only
// when the sequencer is idle and the output register is empty. Seed words are
// written through the register port at byte addresses 0, 8, 16 and 24; the
// user must write them only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module xoshiro256pp_random_generator (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] bound
    input  logic [1:0]  s_axis_tuser,   // [1:0] operation

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [63:0] value

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    x256pp_pkg::fsm_state_t            state_reg, state_next;
    x256pp_pkg::state_ctrl_t           ctrl;
    x256pp_pkg::seed_t                 seed_reg;
    x256pp_pkg::op_t                   op;
    logic                              in_acc;
    logic                              range_reg, range_next;
    logic [x256pp_pkg::DIV_W-1:0]      div_reg,   div_next;
    logic                              m_valid_reg, m_valid_next;
    logic [x256pp_pkg::WORD_W-1:0]     m_data_reg,  m_data_next;
    logic [x256pp_pkg::WORD_W-1:0]     raw;
    logic                              rem_start;
    logic                              rem_done;
    logic [x256pp_pkg::DIV_W-1:0]      rem_val;
    logic                              out_load;
    logic [x256pp_pkg::WORD_W-1:0]     out_val;
    logic [1:0]                        cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:3];
    assign prdata  = seed_reg[cfg_idx];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            seed_reg[cfg_idx] <= pwdata;
        end
    end

    assign op            = x256pp_pkg::op_t'(s_axis_tuser);
    assign s_axis_tready = (state_reg == x256pp_pkg::ST_IDLE) && !m_valid_reg;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        state_next   = state_reg;
        range_next   = range_reg;
        div_next     = div_reg;
        ctrl         = '0;
        rem_start    = 1'b0;
        out_load     = 1'b0;
        out_val      = '0;
        case (state_reg)
            x256pp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (op)
                        x256pp_pkg::OP_RAW: begin
                            ctrl.advance = 1'b1;
                            range_next   = 1'b0;
                            state_next   = x256pp_pkg::ST_MIX;
                        end
                        x256pp_pkg::OP_RANGE: begin
                            if (s_axis_tdata[31] || s_axis_tdata == '0) begin
                                out_load = 1'b1;
                            end else begin
                                ctrl.advance = 1'b1;
                                range_next   = 1'b1;
                                div_next     = s_axis_tdata[x256pp_pkg::DIV_W-1:0];
                                state_next   = x256pp_pkg::ST_MIX;
                            end
                        end
                        x256pp_pkg::OP_LOAD: begin
                            ctrl.load = 1'b1;
                        end
                        x256pp_pkg::OP_CLEAR: begin
                            ctrl.clear = 1'b1;
                        end
                        default: begin
                            ctrl = '0;
                        end
                    endcase
                end
            end
            x256pp_pkg::ST_MIX: begin
                if (range_reg) begin
                    rem_start  = 1'b1;
                    state_next = x256pp_pkg::ST_REM;
                end else begin
                    out_load   = 1'b1;
                    out_val    = raw;
                    state_next = x256pp_pkg::ST_IDLE;
                end
            end
            x256pp_pkg::ST_REM: begin
                if (rem_done) begin
                    out_load   = 1'b1;
                    out_val    = {{(x256pp_pkg::WORD_W - x256pp_pkg::DIV_W){1'b0}}, rem_val};
                    state_next = x256pp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = x256pp_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = out_val;
        end else if (m_axis_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= x256pp_pkg::ST_IDLE;
            range_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            range_reg   <= range_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        div_reg    <= div_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    x256pp_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (ctrl),
        .seed    (seed_reg),
        .raw     (raw)
    );

    x256pp_rem u_rem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (rem_start),
        .dividend  (raw),
        .divisor   (div_reg),
        .done      (rem_done),
        .remainder (rem_val)
    );

`ifndef SYNTHESIS
    // output register stays free while a word is being worked on
    a_busy_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != x256pp_pkg::ST_IDLE) |-> !m_valid_reg)
        else $error("output word pending while sequencer busy");

    // remainder completes only while the sequencer waits for it
    a_rem_done_state: assert property (@(posedge aclk) disable iff (!aresetn)
        rem_done |-> (state_reg == x256pp_pkg::ST_REM))
        else $error("remainder done outside remainder state");

    // a raw request's word reaches the output register after the mix state
    a_raw_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && op == x256pp_pkg::OP_RAW) |=> ##1 m_valid_reg)
        else $error("raw request produced no word");

    // seed load and clear never produce a word
    a_no_word_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && (op == x256pp_pkg::OP_LOAD || op == x256pp_pkg::OP_CLEAR))
        |=> !m_valid_reg)
        else $error("load or clear produced a word");
`endif

endmodule

/* src/x256pp_state.sv */
// ----------------------------------------------------------------------------
// x256pp_state
// four generator words with advance, seed load and clear; output mixing
// is split over the advance cycle and the following one
// ----------------------------------------------------------------------------
module x256pp_state (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  x256pp_pkg::state_ctrl_t             ctrl,
    input  x256pp_pkg::seed_t                   seed,
    output logic [x256pp_pkg::WORD_W-1:0]       raw
);

    logic [x256pp_pkg::WORD_W-1:0] w_reg [4];
    logic [x256pp_pkg::WORD_W-1:0] w_next [4];
    logic [x256pp_pkg::WORD_W-1:0] sum_reg;
    logic [x256pp_pkg::WORD_W-1:0] w0_hold_reg;
    logic [x256pp_pkg::WORD_W-1:0] a2;
    logic [x256pp_pkg::WORD_W-1:0] a3;
    logic [x256pp_pkg::WORD_W-1:0] t;
    logic                          seed_zero;

    assign seed_zero = (seed[0] | seed[1] | seed[2] | seed[3]) == '0;
    assign t  = w_reg[1] << x256pp_pkg::SHIFT_T;
    assign a2 = w_reg[2] ^ w_reg[0];
    assign a3 = w_reg[3] ^ w_reg[1];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_next[i] = w_reg[i];
        end
        if (ctrl.clear) begin
            for (int i = 0; i < 4; i++) begin
                w_next[i] = '0;
            end
        end else if (ctrl.load) begin
            for (int i = 0; i < 4; i++) begin
                w_next[i] = seed[i];
            end
            if (seed_zero) begin
                w_next[0] = x256pp_pkg::WORD_W'(1);
            end
        end else if (ctrl.advance) begin
            w_next[0] = w_reg[0] ^ a3;
            w_next[1] = w_reg[1] ^ a2;
            w_next[2] = a2 ^ t;
            w_next[3] = (a3 << x256pp_pkg::ROT_W3)
                      | (a3 >> (x256pp_pkg::WORD_W - x256pp_pkg::ROT_W3));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                w_reg[i] <= w_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.advance) begin
            sum_reg     <= w_reg[0] + w_reg[3];
            w0_hold_reg <= w_reg[0];
        end
    end

    assign raw = ((sum_reg << x256pp_pkg::ROT_OUT)
               | (sum_reg >> (x256pp_pkg::WORD_W - x256pp_pkg::ROT_OUT)))
               + w0_hold_reg;

endmodule

/* src/x256pp_rem.sv */
// ----------------------------------------------------------------------------
// x256pp_rem
// restoring remainder, 64-bit dividend by 31-bit divisor, one bit a cycle
// ----------------------------------------------------------------------------
module x256pp_rem (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [x256pp_pkg::WORD_W-1:0]       dividend,
    input  logic [x256pp_pkg::DIV_W-1:0]        divisor,
    output logic                                done,
    output logic [x256pp_pkg::DIV_W-1:0]        remainder
);

    localparam int unsigned CNT_W = $clog2(x256pp_pkg::WORD_W);

    logic                            busy_reg,  busy_next;
    logic                            done_reg,  done_next;
    logic [CNT_W-1:0]                cnt_reg,   cnt_next;
    logic [x256pp_pkg::WORD_W-1:0]   dvd_reg,   dvd_next;
    logic [x256pp_pkg::DIV_W-1:0]    div_reg,   div_next;
    logic [x256pp_pkg::DIV_W-1:0]    rem_reg,   rem_next;
    logic [x256pp_pkg::DIV_W:0]      trial;
    logic [x256pp_pkg::DIV_W:0]      diff;

    assign trial = {rem_reg, dvd_reg[x256pp_pkg::WORD_W-1]};
    assign diff  = trial - {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        div_next  = div_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            div_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = dvd_reg << 1;
            if (trial >= {1'b0, div_reg}) begin
                rem_next = diff[x256pp_pkg::DIV_W-1:0];
            end else begin
                rem_next = trial[x256pp_pkg::DIV_W-1:0];
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(x256pp_pkg::WORD_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        div_reg <= div_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule
